@@ rtl/slm_pkg.sv @@
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types, widths and constants of the stereo block level meter.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int SAMPLE_W      = 24;
  localparam int MAX_FRAMES    = 1024;
  localparam int FRAMES_W      = $clog2(MAX_FRAMES + 1);
  localparam int CNT_W         = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int SQ_W          = 2 * SAMPLE_W;
  // largest square is 2^46, times MAX_FRAMES frames
  localparam int SUM_W         = 2 * SAMPLE_W - 2 + FRAMES_W;
  localparam int ZCR_W         = 16;
  localparam int ROOT_W        = SAMPLE_W;
  localparam int SQ_IN_W       = 2 * ROOT_W;
  localparam int FRAME_TOTAL_W = 11;
  localparam int DIV_CNT_W     = $clog2(SUM_W);
  localparam int SQ_CNT_W      = $clog2(ROOT_W);

  localparam int IN_TDATA_W    = 2 * SAMPLE_W;
  localparam int OUT_FIELDS_W  = 4 * SAMPLE_W + 2 * ZCR_W + FRAME_TOTAL_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

  localparam int CFG_W = 2;
  localparam logic [CFG_W-1:0] CH_MONO  = 2'd1;
  localparam logic [CFG_W-1:0] CH_RESET = 2'd2;

  typedef enum logic [1:0] {
    OP_SUM_L,
    OP_SUM_R,
    OP_ZCR_L,
    OP_ZCR_R
  } div_op_t;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_FLUSH,
    ST_SETUP,
    ST_DIV_SUM_L,
    ST_SQRT_L,
    ST_DIV_SUM_R,
    ST_SQRT_R,
    ST_DIV_ZCR_L,
    ST_DIV_ZCR_R,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    div_start;
    div_op_t div_op;
    logic    sqrt_start;
    logic    sqrt_ch;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic block_end;
    logic div_done;
    logic sqrt_done;
    logic out_full;
  } sts_t;

endpackage

@@ rtl/slm_div.sv @@
// ----------------------------------------------------------------------------
// slm_div
// Restoring divider, one quotient bit per cycle, for sums and crossing counts.
// ----------------------------------------------------------------------------
module slm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [slm_pkg::SUM_W-1:0]    dividend,
  input  logic [slm_pkg::FRAMES_W-1:0] divisor,
  output logic                         busy,
  output logic                         done,
  output logic [slm_pkg::SUM_W-1:0]    quotient
);
  import slm_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [FRAMES_W-1:0]  rem;
  logic [FRAMES_W-1:0]  den;
  logic [FRAMES_W:0]    trial;
  logic [FRAMES_W:0]    diff;
  logic                 ge;

  always_comb begin
    trial = {rem, quotient[SUM_W-1]};
    ge    = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      den      <= divisor;
      cnt      <= DIV_CNT_W'(SUM_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (ge) begin
        rem      <= diff[FRAMES_W-1:0];
        quotient <= {quotient[SUM_W-2:0], 1'b1};
      end else begin
        rem      <= trial[FRAMES_W-1:0];
        quotient <= {quotient[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/slm_sqrt.sv @@
// ----------------------------------------------------------------------------
// slm_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module slm_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [slm_pkg::SQ_IN_W-1:0] operand,
  output logic                        busy,
  output logic                        done,
  output logic [slm_pkg::ROOT_W-1:0]  root
);
  import slm_pkg::*;

  logic [SQ_CNT_W-1:0] cnt;
  logic [SQ_IN_W-1:0]  opnd;
  logic [ROOT_W:0]     rem;
  logic [ROOT_W+2:0]   rem_sh;
  logic [ROOT_W+2:0]   trial;
  logic [ROOT_W+2:0]   diff;
  logic                ge;

  always_comb begin
    rem_sh = {rem, opnd[SQ_IN_W-1 -: 2]};
    trial  = (ROOT_W+3)'({root, 2'b01});
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd <= operand;
      root <= '0;
      rem  <= '0;
      cnt  <= SQ_CNT_W'(ROOT_W - 1);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      opnd <= {opnd[SQ_IN_W-3:0], 2'b00};
      if (ge) begin
        rem  <= diff[ROOT_W:0];
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[ROOT_W:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/slm_dp.sv @@
// ----------------------------------------------------------------------------
// slm_dp
// Accumulators, end-of-block arithmetic units and the result register.
// ----------------------------------------------------------------------------
module slm_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  slm_pkg::cmd_t                   cmd,
  output slm_pkg::sts_t                   sts,
  input  logic [slm_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tlast,
  input  logic                            cfg_we,
  input  logic [slm_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [slm_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import slm_pkg::*;

  logic [CFG_W-1:0]    chan_cnt;
  logic [SUM_W-1:0]    sum      [2];
  logic [SAMPLE_W-1:0] peak     [2];
  logic [CNT_W-1:0]    zc       [2];
  logic                prev_pos [2];
  logic [SQ_W-1:0]     sq       [2];
  logic                sq_vld;
  logic [FRAMES_W-1:0] frames;

  logic [SAMPLE_W-1:0] smp [2];
  logic [SAMPLE_W-1:0] mag [2];
  logic                pos [2];

  logic [ROOT_W-1:0]   rms [2];
  logic [ZCR_W-1:0]    zcr [2];
  div_op_t             op_q;
  logic                sq_ch_q;

  logic [SUM_W-1:0]    div_dividend;
  logic                div_busy;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;
  logic                sqrt_busy;
  logic                sqrt_done;
  logic [ROOT_W-1:0]   sqrt_root;

  logic                mono;

  assign smp[0] = s_tdata[SAMPLE_W-1:0];
  assign smp[1] = s_tdata[2*SAMPLE_W-1:SAMPLE_W];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      // most negative sample wraps to 2^23, which still fits unsigned
      mag[c] = smp[c][SAMPLE_W-1] ? (~smp[c] + 1'b1) : smp[c];
      pos[c] = !smp[c][SAMPLE_W-1] && (smp[c] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_cnt <= CH_RESET;
    end else if (cfg_we) begin
      chan_cnt <= cfg_wdata;
    end
  end

  // accumulate: squares are registered, then added to the sum in the cycle after
  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      frames <= '0;
      sq_vld <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        sum[c]      <= '0;
        peak[c]     <= '0;
        zc[c]       <= '0;
        prev_pos[c] <= 1'b0;
      end
    end else begin
      sq_vld <= cmd.accept;
      for (int c = 0; c < 2; c++) begin
        if (sq_vld) begin
          sum[c] <= sum[c] + SUM_W'(sq[c]);
        end
      end
      if (cmd.accept) begin
        frames <= frames + 1'b1;
        for (int c = 0; c < 2; c++) begin
          if (mag[c] > peak[c]) begin
            peak[c] <= mag[c];
          end
          if ((frames != '0) && (pos[c] != prev_pos[c])) begin
            zc[c] <= zc[c] + 1'b1;
          end
          prev_pos[c] <= pos[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int c = 0; c < 2; c++) begin
        sq[c] <= mag[c] * mag[c];
      end
    end
  end

  always_comb begin
    case (cmd.div_op)
      OP_SUM_L: div_dividend = sum[0];
      OP_SUM_R: div_dividend = sum[1];
      OP_ZCR_L: div_dividend = SUM_W'({zc[0], {ZCR_W{1'b0}}});
      OP_ZCR_R: div_dividend = SUM_W'({zc[1], {ZCR_W{1'b0}}});
      default:  div_dividend = '0;
    endcase
  end

  slm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (frames),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  slm_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.sqrt_start),
    .operand (div_quo[SQ_IN_W-1:0]),
    .busy    (sqrt_busy),
    .done    (sqrt_done),
    .root    (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      op_q <= cmd.div_op;
    end
    if (cmd.sqrt_start) begin
      sq_ch_q <= cmd.sqrt_ch;
    end
    if (div_done) begin
      case (op_q)
        OP_ZCR_L: zcr[0] <= div_quo[ZCR_W-1:0];
        OP_ZCR_R: zcr[1] <= div_quo[ZCR_W-1:0];
        default: ;
      endcase
    end
    if (sqrt_done) begin
      rms[sq_ch_q] <= sqrt_root;
    end
  end

  assign mono = (chan_cnt == CH_MONO);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {{OUT_PAD_W{1'b0}},
                  FRAME_TOTAL_W'(frames),
                  mono ? {ZCR_W{1'b0}} : zcr[1],
                  zcr[0],
                  mono ? {SAMPLE_W{1'b0}} : peak[1],
                  peak[0],
                  mono ? {ROOT_W{1'b0}} : rms[1],
                  rms[0]};
    end
  end

  assign sts.block_end = s_tlast || (frames == FRAMES_W'(MAX_FRAMES - 1));
  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.out_full  = m_tvalid;

`ifndef SYNTHESIS
  a_clear_on_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (frames == '0) && m_tvalid)
    else $error("accumulators not cleared on result load");

  a_frames_bound: assert property (@(posedge clk) disable iff (rst)
    frames <= FRAMES_W'(MAX_FRAMES))
    else $error("frame count beyond block limit");

  a_zc_bound: assert property (@(posedge clk) disable iff (rst)
    (frames != '0) |-> (FRAMES_W'(zc[0]) < frames) && (FRAMES_W'(zc[1]) < frames))
    else $error("crossing count not below frame count");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy && !cmd.accept)
    else $error("divider started while busy or accumulating");

  a_sqrt_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.sqrt_start |-> !sqrt_busy && !div_busy)
    else $error("square root started while a unit is busy");
`endif

endmodule

@@ rtl/slm_ctrl.sv @@
// ----------------------------------------------------------------------------
// slm_ctrl
// Sequencer: frame accumulation, then the end-of-block divide/sqrt steps.
// ----------------------------------------------------------------------------
module slm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  slm_pkg::sts_t sts,
  output slm_pkg::cmd_t cmd
);
  import slm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.div_op     = OP_SUM_L;
    s_tready       = 1'b0;
    case (state)
      ST_ACC: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid && sts.block_end) begin
          state_next = ST_FLUSH;
        end
      end
      // last square lands in the sum here
      ST_FLUSH: begin
        state_next = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = OP_SUM_L;
        state_next    = ST_DIV_SUM_L;
      end
      ST_DIV_SUM_L: begin
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          cmd.sqrt_ch    = 1'b0;
          state_next     = ST_SQRT_L;
        end
      end
      ST_SQRT_L: begin
        if (sts.sqrt_done) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_SUM_R;
          state_next    = ST_DIV_SUM_R;
        end
      end
      ST_DIV_SUM_R: begin
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          cmd.sqrt_ch    = 1'b1;
          state_next     = ST_SQRT_R;
        end
      end
      ST_SQRT_R: begin
        if (sts.sqrt_done) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_ZCR_L;
          state_next    = ST_DIV_ZCR_L;
        end
      end
      ST_DIV_ZCR_L: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_ZCR_R;
          state_next    = ST_DIV_ZCR_R;
        end
      end
      ST_DIV_ZCR_R: begin
        if (sts.div_done) begin
          state_next = ST_LOAD;
        end
      end
      // wait for the previous result beat to leave
      ST_LOAD: begin
        if (!sts.out_full) begin
          cmd.load_out = 1'b1;
          state_next   = ST_ACC;
        end
      end
      default: begin
        state_next = ST_ACC;
      end
    endcase
  end

endmodule

@@ rtl/stereo_block_level_meter.sv @@
// ----------------------------------------------------------------------------
// stereo_block_level_meter
// Per-channel RMS, peak and zero-crossing rate over blocks of stereo frames.
// ----------------------------------------------------------------------------
// throughput: one frame per cycle while a block is accumulating
// end of block: input is held off while the bit-serial divider (four divides)
//   and square root run
// the result beat is registered; the next block accumulates while it waits
// rst is synchronous: accumulators cleared, channel_count back to stereo
module stereo_block_level_meter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // sample_left, sample_right
  input  logic [slm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // rms_left, rms_right, peak_left, peak_right, zcr_left, zcr_right,
  // frame_total, zero fill
  output logic [slm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [slm_pkg::CFG_W-1:0]       cfg_wdata
);
  import slm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  slm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  slm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_axis_tdata),
    .s_tlast   (s_axis_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_tdata   (m_axis_tdata)
  );

endmodule
